// ===== rtl/lcm_pkg.sv =====
// ----------------------------------------------------------------------------
// lcm_pkg
// Shared types and constants for the least common multiple block.
// ----------------------------------------------------------------------------
package lcm_pkg;

  // Width of the operand and result fields on the stream ports
  localparam int unsigned FIELD_W = 32;

  // Operation of the shared add/subtract unit
  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_e;

endpackage

// ===== rtl/lcm_alu.sv =====
// ----------------------------------------------------------------------------
// lcm_alu
// Shared add/subtract unit, used by the GCD, divide and multiply steps.
// ----------------------------------------------------------------------------
module lcm_alu #(
  parameter int unsigned WIDTH = 32
) (
  input  lcm_pkg::alu_op_e  op_i,
  input  logic [WIDTH:0]    a_i,
  input  logic [WIDTH-1:0]  b_i,
  output logic [WIDTH+1:0]  res_o   // MSB set on subtract means a < b
);
  import lcm_pkg::*;

  logic [WIDTH+1:0] ext_a;
  logic [WIDTH+1:0] ext_b;

  assign ext_a = {1'b0, a_i};
  assign ext_b = {2'b00, b_i};
  assign res_o = (op_i == ALU_SUB) ? (ext_a - ext_b) : (ext_a + ext_b);

endmodule

// ===== rtl/least_common_multiple.sv =====
// ----------------------------------------------------------------------------
// least_common_multiple
// Least common multiple of two unsigned operands on a single shared adder.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: s_axis_tdata carries operand_a in [31:0] and operand_b in
//   [63:32]; operands are taken modulo 2**WIDTH. Output stream: m_axis_tdata
//   carries the multiple, m_axis_tuser is the overflow flag. On overflow or a
//   zero operand the multiple is zero (a zero operand never flags overflow).
//   One word out for every word in, in order.
// Timing:
//   The block takes one word at a time; s_axis_tready is high only while idle.
//   A word runs a binary GCD (one shift, subtract or swap per cycle), a
//   restoring divide by the GCD and a shift-add multiply, all on one
//   add/subtract unit, then the output register is loaded. A zero operand
//   skips the GCD, divide and multiply and goes straight to loading the
//   output register. After the output register is loaded the sequencer
//   returns to idle, where the next word is taken.
// Stall and reset:
//   The output register holds its word until m_axis_tready; a finished result
//   waits in the sequencer until the register is free. The next word is taken
//   while the previous result still waits downstream. Reset empties the output
//   register and returns the sequencer to idle.
// ----------------------------------------------------------------------------
module least_common_multiple #(
  parameter int unsigned WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [31:0] operand_a, [63:32] operand_b
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [lcm_pkg::FIELD_W-1:0] m_axis_tdata,  // [31:0] multiple
  output logic        m_axis_tuser    // [0] overflow
);
  import lcm_pkg::*;

  localparam int unsigned CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WIDTH - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GCD,
    ST_DIV,
    ST_MUL,
    ST_FIN
  } state_e;

  state_e             state_q;
  logic [WIDTH-1:0]   x_q;     // GCD operand, then remainder, then product high
  logic [WIDTH-1:0]   y_q;     // GCD operand, then the GCD itself
  logic [WIDTH-1:0]   a_q;     // dividend/quotient, then multiplier/product low
  logic [WIDTH-1:0]   b_q;
  logic [CNT_W-1:0]   k_q;     // common power of two
  logic [CNT_W-1:0]   cnt_q;
  logic               out_valid_q;
  logic [FIELD_W-1:0] out_data_q;
  logic               out_ovf_q;

  logic [WIDTH-1:0]   in_a;
  logic [WIDTH-1:0]   in_b;
  alu_op_e            alu_op;
  logic [WIDTH:0]     alu_a;
  logic [WIDTH-1:0]   alu_b;
  logic [WIDTH+1:0]   alu_res;
  logic               alu_neg;
  logic [WIDTH-1:0]   gcd_val;
  logic               out_free;

  assign in_a     = WIDTH'(s_axis_tdata[FIELD_W-1:0]);
  assign in_b     = WIDTH'(s_axis_tdata[2*FIELD_W-1:FIELD_W]);
  assign alu_neg  = alu_res[WIDTH+1];
  assign gcd_val  = (x_q | y_q) << k_q;
  assign out_free = !out_valid_q || m_axis_tready;

  always_comb begin
    alu_op = ALU_ADD;
    alu_a  = {1'b0, x_q};
    alu_b  = y_q;
    case (state_q)
      ST_GCD: begin
        alu_op = ALU_SUB;
      end
      ST_DIV: begin
        alu_op = ALU_SUB;
        alu_a  = {x_q, a_q[WIDTH-1]};
      end
      ST_MUL: begin
        alu_b  = a_q[0] ? b_q : '0;
      end
      default: begin
        alu_op = ALU_ADD;
      end
    endcase
  end

  lcm_alu #(
    .WIDTH (WIDTH)
  ) u_alu (
    .op_i  (alu_op),
    .a_i   (alu_a),
    .b_i   (alu_b),
    .res_o (alu_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      x_q         <= '0;
      y_q         <= '0;
      a_q         <= '0;
      b_q         <= '0;
      k_q         <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      out_ovf_q   <= 1'b0;
    end else begin
      if (state_q == ST_FIN && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            k_q   <= '0;
            cnt_q <= '0;
            if (in_a == '0 || in_b == '0) begin
              x_q     <= '0;
              a_q     <= '0;
              state_q <= ST_FIN;
            end else begin
              x_q     <= in_a;
              y_q     <= in_b;
              a_q     <= in_a;
              b_q     <= in_b;
              state_q <= ST_GCD;
            end
          end
        end
        ST_GCD: begin
          if (x_q == '0 || y_q == '0) begin
            y_q     <= gcd_val;
            x_q     <= '0;
            cnt_q   <= '0;
            state_q <= ST_DIV;
          end else if (!x_q[0] && !y_q[0]) begin
            x_q <= x_q >> 1;
            y_q <= y_q >> 1;
            k_q <= k_q + 1'b1;
          end else if (!x_q[0]) begin
            x_q <= x_q >> 1;
          end else if (!y_q[0]) begin
            y_q <= y_q >> 1;
          end else if (alu_neg) begin
            // both odd and x < y: swap so the next subtract is positive
            x_q <= y_q;
            y_q <= x_q;
          end else begin
            x_q <= alu_res[WIDTH-1:0];
          end
        end
        ST_DIV: begin
          if (alu_neg) begin
            x_q <= alu_a[WIDTH-1:0];
            a_q <= {a_q[WIDTH-2:0], 1'b0};
          end else begin
            x_q <= alu_res[WIDTH-1:0];
            a_q <= {a_q[WIDTH-2:0], 1'b1};
          end
          if (cnt_q == CNT_LAST) begin
            cnt_q   <= '0;
            state_q <= ST_MUL;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_MUL: begin
          x_q   <= alu_res[WIDTH:1];
          a_q   <= {alu_res[0], a_q[WIDTH-1:1]};
          if (cnt_q == CNT_LAST) begin
            cnt_q   <= '0;
            state_q <= ST_FIN;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_FIN: begin
          // product high half nonzero means the multiple does not fit
          if (out_free) begin
            out_ovf_q   <= |x_q;
            out_data_q  <= (|x_q) ? '0 : FIELD_W'(a_q);
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_ovf_q;

  a_ovf_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("overflow result not zero");

  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("ready still high after accepting a word");

  a_div_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> y_q != '0)
    else $error("divide by zero GCD");

  a_rem_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV && $past(state_q) == ST_DIV |-> x_q < y_q)
    else $error("remainder not below divisor");

endmodule

// ===== tb/least_common_multiple_test.sv =====
// ----------------------------------------------------------------------------
// least_common_multiple_test
// Self-checking stream testbench for the least common multiple block. A
// queue of operand pairs (directed corner cases, then random pairs weighted
// toward results that fit) feeds a bursty driver. A monitor checks each
// output word against a behavioral LCM predictor, in order, while the
// receiver stalls on its own pattern, including one long hold-off.
// ----------------------------------------------------------------------------
module least_common_multiple_test;

  localparam int unsigned WIDTH         = 32;
  localparam int unsigned RANDOM_PAIRS  = 400;
  localparam int unsigned LONG_HOLD     = 2000;
  localparam int unsigned TAIL_CYCLES   = 8 * WIDTH;

  typedef struct packed {
    logic [lcm_pkg::FIELD_W-1:0] multiple;
    logic                        overflow;
  } lcm_result_t;

  typedef struct {
    logic [63:0] word;
    bit          wait_idle;  // hold until every result is back
  } operand_pair_t;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        s_axis_tvalid = 1'b0;
  logic                        s_axis_tready;
  logic [63:0]                 s_axis_tdata = '0;   // [31:0] operand_a, [63:32] operand_b
  logic                        m_axis_tvalid;
  logic                        m_axis_tready = 1'b0;
  logic [lcm_pkg::FIELD_W-1:0] m_axis_tdata;        // [31:0] multiple
  logic                        m_axis_tuser;        // [0] overflow

  operand_pair_t pending_q[$];
  lcm_result_t   expected_lcm_q[$];
  int unsigned   error_count  = 0;
  int unsigned   words_out    = 0;
  bit            in_accept    = 1'b0;

  least_common_multiple #(
    .WIDTH(WIDTH)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Euclid on 64-bit values, then divide and multiply with a bound check
  function automatic lcm_result_t lcm_expected(logic [63:0] word);
    longint unsigned a, b, x, y, r, q, lim;
    lcm_result_t res;
    lim = (64'd1 << WIDTH) - 64'd1;
    a = word[31:0] & lim;
    b = word[63:32] & lim;
    res = '0;
    if (a != 0 && b != 0) begin
      x = a;
      y = b;
      while (y != 0) begin
        r = x % y;
        x = y;
        y = r;
      end
      q = a / x;
      if (q > lim / b) begin
        res.overflow = 1'b1;
      end else begin
        res.multiple = lcm_pkg::FIELD_W'(q * b);
      end
    end
    return res;
  endfunction

  // Random value of at most w bits, with w drawn from lo..hi
  function automatic logic [31:0] rand_width(int unsigned lo, int unsigned hi);
    int unsigned w;
    logic [31:0] mask;
    w = $urandom_range(lo, hi);
    mask = 32'((64'd1 << w) - 64'd1);
    return $urandom & mask;
  endfunction

  function automatic logic [63:0] random_pair();
    logic [31:0] a, b, g;
    int unsigned wa;
    a = '0;
    b = '0;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        // common factor times small cofactors
        g = rand_width(1, 12);
        a = g * rand_width(1, 10);
        b = g * rand_width(1, 10);
      end
      3, 4: begin
        a = rand_width(1, 16);
        b = rand_width(1, 16);
      end
      5, 6: begin
        a = $urandom;
        b = $urandom;
      end
      7: begin
        if ($urandom_range(0, 3) == 0) begin
          a = '0;
          b = '0;
        end else if ($urandom_range(0, 1) == 0) begin
          b = $urandom;
        end else begin
          a = $urandom;
        end
      end
      8: begin
        a = rand_width(1, 16);
        b = a * rand_width(0, 16);
      end
      default: begin
        // bit lengths summing near 32: lands on both sides of overflow
        wa = $urandom_range(1, 31);
        a = rand_width(wa, wa);
        b = rand_width(32 - wa, (wa == 1) ? 32 : 33 - wa);
      end
    endcase
    return {b, a};
  endfunction

  // Stimulus and end of run
  initial begin
    logic [63:0] directed[$];
    operand_pair_t item;
    directed = '{
      {32'd0, 32'd0},
      {32'd7, 32'd0},
      {32'd0, 32'hFFFF_FFFF},
      {32'd1, 32'd1},
      {32'hFFFF_FFFF, 32'hFFFF_FFFF},
      {32'd1, 32'hFFFF_FFFF},
      {32'hFFFF_FFFE, 32'hFFFF_FFFF},
      {32'h8000_0000, 32'h8000_0000},
      {32'd3, 32'h8000_0000},
      {32'h0001_0000, 32'h0001_0000},
      {32'h0001_0001, 32'h0001_0000},
      {32'h0001_0001, 32'h0000_FFFF},
      {32'd6, 32'd4},
      {32'd65521, 32'd65519},
      {32'd65537, 32'd65539},
      {32'hAAAA_AAAA, 32'h5555_5555},
      {32'd2, 32'h8000_0001},
      {32'h7FFF_FFFF, 32'd2}
    };
    foreach (directed[i]) begin
      item.word = directed[i];
      item.wait_idle = 1'b0;
      pending_q.push_back(item);
    end
    for (int i = 0; i < RANDOM_PAIRS; i++) begin
      item.word = random_pair();
      item.wait_idle = (i == 0) || (i == RANDOM_PAIRS / 2);
      pending_q.push_back(item);
    end

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending_q.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (expected_lcm_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (error_count == 0) begin
      $display("[least_common_multiple] OK");
    end else begin
      $display("[least_common_multiple] ERROR");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("[least_common_multiple] ERROR");
    $finish;
  end

  // Sender: bursts of offered words separated by random gaps
  int unsigned burst_left = 1;
  int unsigned gap_left   = 0;

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (in_accept) void'(pending_q.pop_front());
      if (s_axis_tvalid && !in_accept) begin
        // word still on offer: hold it
      end else if (pending_q.size() == 0) begin
        s_axis_tvalid <= 1'b0;
      end else if (gap_left != 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_q[0].wait_idle && expected_lcm_q.size() != 0) begin
        s_axis_tvalid <= 1'b0;
      end else begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pending_q[0].word;
        burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 8);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end
      end
    end
  end

  // Receiver: ready pattern switches between modes; one long hold-off
  int unsigned mode_left = 0;
  int unsigned ready_mode = 0;
  int unsigned hold_left = 0;
  bit          long_hold_done = 1'b0;

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (!long_hold_done && words_out >= 100) begin
      long_hold_done = 1'b1;
      hold_left = LONG_HOLD;
      m_axis_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        ready_mode = $urandom_range(0, 2);
        mode_left = $urandom_range(16, 128);
      end
      mode_left--;
      case (ready_mode)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
        default: m_axis_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Monitor: input acceptance feeds the predictor, output words are checked
  always @(posedge clk_i) begin
    lcm_result_t want;
    in_accept = rst_ni && s_axis_tvalid && s_axis_tready;
    if (in_accept) expected_lcm_q.push_back(lcm_expected(s_axis_tdata));
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      words_out++;
      if (expected_lcm_q.size() == 0) begin
        error_count++;
        $display("%0t: unexpected word: expected none, got multiple %h overflow %b",
                 $realtime, m_axis_tdata, m_axis_tuser);
      end else begin
        want = expected_lcm_q.pop_front();
        if (m_axis_tdata !== want.multiple || m_axis_tuser !== want.overflow) begin
          error_count++;
          $display("%0t: mismatch: expected multiple %h overflow %b, got %h %b",
                   $realtime, want.multiple, want.overflow, m_axis_tdata,
                   m_axis_tuser);
        end
      end
    end
  end

endmodule
